### rtl/tcle_pkg.sv
// ----------------------------------------------------------------------------
// tcle_pkg: shared types and constants of the text cell layout engine
// font table, op descriptor passed from front to back, result codes
// ----------------------------------------------------------------------------
package tcle_pkg;

   // defaults for the top level parameters
   localparam int COORD_BITS_DEF      = 11;
   localparam int OP_QUEUE_DEPTH_DEF  = 4;
   localparam int RSP_QUEUE_DEPTH_DEF = 4;

   localparam int GLYPH_BITS = 35;
   localparam int DIM_BITS   = 11;

   // result action codes
   localparam logic [1:0] ACT_CLEAR   = 2'd0;
   localparam logic [1:0] ACT_DRAW    = 2'd1;
   localparam logic [1:0] ACT_REFRESH = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PIXEL_SCALE   = 2'd2;

   localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RST  = 11'd320;
   localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RST = 11'd240;
   localparam logic [1:0]          PIXEL_SCALE_RST   = 2'd1;

   // byte codes
   localparam logic [7:0] CHR_LF      = 8'h0A;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_DEL     = 8'h7F;
   localparam logic [7:0] CHR_QMARK   = 8'h3F;
   localparam logic [7:0] CHR_LOW_A   = 8'h61;
   localparam logic [7:0] CHR_LOW_Z   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] UTF8_TOP    = 8'hC0;
   localparam logic [7:0] UTF8_CONT   = 8'h80;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_NEWLINE,
      OP_DRAW,
      OP_REFRESH
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [GLYPH_BITS-1:0] glyph;
      logic                  last;
   } op_type;

   typedef enum logic [1:0] {
      BK_FIRST,
      BK_CHECK,
      BK_DRAW,
      BK_REFRESH
   } bk_state_type;

   function automatic logic [GLYPH_BITS-1:0] pack_cols(input logic [6:0] c0,
                                                       input logic [6:0] c1,
                                                       input logic [6:0] c2,
                                                       input logic [6:0] c3,
                                                       input logic [6:0] c4);
      return {c4, c3, c2, c1, c0};
   endfunction

   // 5x7 character generator, lower case folded to upper case
   function automatic logic [GLYPH_BITS-1:0] glyph_for(input logic [7:0] ch);
      logic [7:0]            up;
      logic [GLYPH_BITS-1:0] g;
      up = ch;
      if (ch >= CHR_LOW_A && ch <= CHR_LOW_Z) begin
         up = ch - CASE_OFFSET;
      end
      case (up)
         8'h20: g = '0;
         8'h30: g = pack_cols(7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E);
         8'h31: g = pack_cols(7'h00, 7'h42, 7'h7F, 7'h40, 7'h00);
         8'h32: g = pack_cols(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
         8'h33: g = pack_cols(7'h21, 7'h41, 7'h45, 7'h4B, 7'h31);
         8'h34: g = pack_cols(7'h18, 7'h14, 7'h12, 7'h7F, 7'h10);
         8'h35: g = pack_cols(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
         8'h36: g = pack_cols(7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30);
         8'h37: g = pack_cols(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
         8'h38: g = pack_cols(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
         8'h39: g = pack_cols(7'h06, 7'h49, 7'h49, 7'h29, 7'h1E);
         8'h41: g = pack_cols(7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E);
         8'h42: g = pack_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h36);
         8'h43: g = pack_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h22);
         8'h44: g = pack_cols(7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C);
         8'h45: g = pack_cols(7'h7F, 7'h49, 7'h49, 7'h49, 7'h41);
         8'h46: g = pack_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h01);
         8'h47: g = pack_cols(7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A);
         8'h48: g = pack_cols(7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F);
         8'h49: g = pack_cols(7'h00, 7'h41, 7'h7F, 7'h41, 7'h00);
         8'h4A: g = pack_cols(7'h20, 7'h40, 7'h41, 7'h3F, 7'h01);
         8'h4B: g = pack_cols(7'h7F, 7'h08, 7'h14, 7'h22, 7'h41);
         8'h4C: g = pack_cols(7'h7F, 7'h40, 7'h40, 7'h40, 7'h40);
         8'h4D: g = pack_cols(7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F);
         8'h4E: g = pack_cols(7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F);
         8'h4F: g = pack_cols(7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E);
         8'h50: g = pack_cols(7'h7F, 7'h09, 7'h09, 7'h09, 7'h06);
         8'h51: g = pack_cols(7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E);
         8'h52: g = pack_cols(7'h7F, 7'h09, 7'h19, 7'h29, 7'h46);
         8'h53: g = pack_cols(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
         8'h54: g = pack_cols(7'h01, 7'h01, 7'h7F, 7'h01, 7'h01);
         8'h55: g = pack_cols(7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F);
         8'h56: g = pack_cols(7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F);
         8'h57: g = pack_cols(7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F);
         8'h58: g = pack_cols(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
         8'h59: g = pack_cols(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
         8'h5A: g = pack_cols(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
         8'h21: g = pack_cols(7'h00, 7'h00, 7'h5F, 7'h00, 7'h00);
         8'h22: g = pack_cols(7'h00, 7'h07, 7'h00, 7'h07, 7'h00);
         8'h27: g = pack_cols(7'h00, 7'h05, 7'h03, 7'h00, 7'h00);
         8'h2C: g = pack_cols(7'h00, 7'h50, 7'h30, 7'h00, 7'h00);
         8'h2D: g = pack_cols(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
         8'h2E: g = pack_cols(7'h00, 7'h60, 7'h60, 7'h00, 7'h00);
         8'h3A: g = pack_cols(7'h00, 7'h36, 7'h36, 7'h00, 7'h00);
         8'h3B: g = pack_cols(7'h00, 7'h56, 7'h36, 7'h00, 7'h00);
         8'h2F: g = pack_cols(7'h20, 7'h10, 7'h08, 7'h04, 7'h02);
         8'h28: g = pack_cols(7'h00, 7'h1C, 7'h22, 7'h41, 7'h00);
         8'h29: g = pack_cols(7'h00, 7'h41, 7'h22, 7'h1C, 7'h00);
         default: g = pack_cols(7'h02, 7'h01, 7'h51, 7'h09, 7'h06);
      endcase
      return g;
   endfunction

endpackage

### rtl/tcle_fifo.sv
// ----------------------------------------------------------------------------
// tcle_fifo: small register queue
// first-word-fall-through queue with full and empty flags
// ----------------------------------------------------------------------------
module tcle_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full  = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/tcle_front.sv
// ----------------------------------------------------------------------------
// tcle_front: input classifier
// sorts each incoming byte or command into an op and looks up its glyph
// ----------------------------------------------------------------------------
module tcle_front (
   input  logic            req_push,
   input  logic            req_command,
   input  logic [7:0]      req_text_byte,
   input  logic            req_last_of_text,
   input  logic            op_full,
   output logic            op_push,
   output tcle_pkg::op_type op
);
   import tcle_pkg::*;

   logic       keep;
   logic [7:0] draw_char;

   always_comb begin
      keep      = 1'b1;
      draw_char = req_text_byte;
      op.kind   = OP_DRAW;
      op.last   = req_last_of_text;
      if (req_command) begin
         op.kind = OP_CLEAR;
      end else if (req_text_byte == CHR_LF) begin
         op.kind = OP_NEWLINE;
      end else if (req_text_byte == CHR_CR ||
                   (req_text_byte & UTF8_TOP) == UTF8_CONT) begin
         // ignored byte: only a refresh survives
         op.kind = OP_REFRESH;
         keep    = req_last_of_text;
      end else if (req_text_byte < CHR_SPACE || req_text_byte >= CHR_DEL) begin
         draw_char = CHR_QMARK;
      end
      op.glyph = glyph_for(draw_char);
      op_push  = req_push && !op_full && keep;
   end

endmodule

### rtl/tcle_back.sv
// ----------------------------------------------------------------------------
// tcle_back: layout sequencer
// keeps the cursor and turns each op into clear, draw and refresh results
// ----------------------------------------------------------------------------
module tcle_back #(
   parameter int COORD_BITS = tcle_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tcle_pkg::DIM_BITS-1:0]   screen_width,
   input  logic [tcle_pkg::DIM_BITS-1:0]   screen_height,
   input  logic [1:0]                      pixel_scale,
   input  logic                            op_valid,
   input  tcle_pkg::op_type                op,
   output logic                            op_pop,
   input  logic                            res_full,
   output logic                            res_push,
   output logic [1:0]                      res_action,
   output logic [COORD_BITS-1:0]           res_cell_x,
   output logic [COORD_BITS-1:0]           res_cell_y,
   output logic [tcle_pkg::GLYPH_BITS-1:0] res_glyph_bits,
   output logic                            res_last
);
   import tcle_pkg::*;

   localparam int CurW = COORD_BITS + 1;
   localparam int SumW = (COORD_BITS + 2 > DIM_BITS + 1) ? COORD_BITS + 2 : DIM_BITS + 1;

   bk_state_type   state_ff, state_in;
   logic [CurW-1:0] col_ff, col_in;
   logic [CurW-1:0] row_ff, row_in;

   logic [1:0]      s;
   logic [2:0]      s2;
   logic [4:0]      s6, s7, s9;
   logic [CurW-1:0] row_nl;
   logic            wrap_need, clear_need, go;

   always_comb begin
      s          = (pixel_scale == 2'd0) ? 2'd1 : pixel_scale;
      s2         = {s, 1'b0};
      s6         = 5'(s) * 5'd6;
      s7         = 5'(s) * 5'd7;
      s9         = 5'(s) * 5'd9;
      row_nl     = row_ff + CurW'(s9);
      wrap_need  = (SumW'(col_ff) + SumW'(s6)) > SumW'(screen_width);
      clear_need = (SumW'(row_ff) + SumW'(s7)) > SumW'(screen_height);
      go         = op_valid && !res_full;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_FIRST: begin
            if (go) begin
               case (op.kind)
                  OP_CLEAR:   state_in = op.last ? BK_REFRESH : BK_FIRST;
                  OP_NEWLINE: state_in = BK_CHECK;
                  OP_DRAW: begin
                     if (wrap_need) begin
                        state_in = BK_CHECK;
                     end else begin
                        state_in = op.last ? BK_REFRESH : BK_FIRST;
                     end
                  end
                  default:    state_in = BK_FIRST;
               endcase
            end
         end
         BK_CHECK: begin
            if (go) begin
               if (op.kind == OP_DRAW) begin
                  state_in = BK_DRAW;
               end else begin
                  state_in = op.last ? BK_REFRESH : BK_FIRST;
               end
            end
         end
         BK_DRAW: begin
            if (go) begin
               state_in = op.last ? BK_REFRESH : BK_FIRST;
            end
         end
         BK_REFRESH: begin
            if (go) begin
               state_in = BK_FIRST;
            end
         end
         default: state_in = BK_FIRST;
      endcase
   end

   // outputs and cursor update
   always_comb begin
      res_push       = 1'b0;
      res_action     = ACT_CLEAR;
      res_glyph_bits = '0;
      res_last       = 1'b0;
      op_pop         = 1'b0;
      col_in         = col_ff;
      row_in         = row_ff;
      case (state_ff)
         BK_FIRST: begin
            if (go) begin
               case (op.kind)
                  OP_CLEAR: begin
                     res_push = 1'b1;
                     res_last = !op.last;
                     op_pop   = !op.last;
                     col_in   = CurW'(s2);
                     row_in   = CurW'(s2);
                  end
                  OP_NEWLINE: begin
                     col_in = CurW'(s2);
                     row_in = row_nl;
                  end
                  OP_DRAW: begin
                     if (wrap_need) begin
                        col_in = CurW'(s2);
                        row_in = row_nl;
                     end else begin
                        res_push       = 1'b1;
                        res_action     = ACT_DRAW;
                        res_glyph_bits = op.glyph;
                        res_last       = !op.last;
                        op_pop         = !op.last;
                        col_in         = col_ff + CurW'(s6);
                     end
                  end
                  default: begin
                     res_push   = 1'b1;
                     res_action = ACT_REFRESH;
                     res_last   = 1'b1;
                     op_pop     = 1'b1;
                  end
               endcase
            end
         end
         BK_CHECK: begin
            if (go) begin
               op_pop = (op.kind != OP_DRAW) && !op.last;
               if (clear_need) begin
                  res_push = 1'b1;
                  res_last = (op.kind != OP_DRAW) && !op.last;
                  col_in   = CurW'(s2);
                  row_in   = CurW'(s2);
               end
            end
         end
         BK_DRAW: begin
            if (go) begin
               res_push       = 1'b1;
               res_action     = ACT_DRAW;
               res_glyph_bits = op.glyph;
               res_last       = !op.last;
               op_pop         = !op.last;
               col_in         = col_ff + CurW'(s6);
            end
         end
         BK_REFRESH: begin
            if (go) begin
               res_push   = 1'b1;
               res_action = ACT_REFRESH;
               res_last   = 1'b1;
               op_pop     = 1'b1;
            end
         end
         default: ;
      endcase
      res_cell_x = (res_action == ACT_DRAW) ? col_ff[COORD_BITS-1:0] : '0;
      res_cell_y = (res_action == ACT_DRAW) ? row_ff[COORD_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_FIRST;
         col_ff   <= CurW'(2);
         row_ff   <= CurW'(2);
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule

### rtl/text_cell_layout_engine.sv
// ----------------------------------------------------------------------------
// text_cell_layout_engine: text to glyph cell command stream
// cursor keeping layout of text bytes into 5x7 glyph draw commands
// ----------------------------------------------------------------------------
// usage
//   input queue: drive req_command, req_text_byte, req_last_of_text and
//   raise req_push; a transfer happens on each edge with req_full low.
//   result queue: while rsp_empty is low the oldest result sits on the
//   rsp_ ports; raising rsp_pop takes it. rsp_last marks the final result
//   of one input, and a byte that causes nothing gives no result at all.
//   csr port: csr_wr_en writes csr_wdata to register csr_index (0 width,
//   1 height, 2 pixel scale) at the edge; write only while idle.
// timing
//   a result passes the op queue register and then the result queue
//   register before it shows on the rsp_ ports. the layout sequencer
//   handles each draw, clear command or refresh in its own step, and
//   each line wrap or line feed in the line step, then the bottom check
//   that carries any clear; a wrapped draw then draws in a step of its
//   own, and a refresh follows where the input asks for one.
//   a front classifier feeds the sequencer through a short op queue, so
//   inputs keep flowing until that queue fills.
// reset and stall
//   reset empties both queues, restores 320x240 at scale 1 and homes the
//   cursor to (2,2). a stalled receiver fills the result queue, then the
//   sequencer holds, then the op queue fills and req_full rises.
module text_cell_layout_engine #(
   parameter int COORD_BITS      = tcle_pkg::COORD_BITS_DEF,
   parameter int OP_QUEUE_DEPTH  = tcle_pkg::OP_QUEUE_DEPTH_DEF,
   parameter int RSP_QUEUE_DEPTH = tcle_pkg::RSP_QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input queue side
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_command,
   input  logic [7:0]                      req_text_byte,
   input  logic                            req_last_of_text,
   // result queue side
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [1:0]                      rsp_action,
   output logic [COORD_BITS-1:0]           rsp_cell_x,
   output logic [COORD_BITS-1:0]           rsp_cell_y,
   output logic [tcle_pkg::GLYPH_BITS-1:0] rsp_glyph_bits,
   output logic                            rsp_last,
   // register write port
   input  logic                            csr_wr_en,
   input  logic [1:0]                      csr_index,
   input  logic [tcle_pkg::DIM_BITS-1:0]   csr_wdata
);
   import tcle_pkg::*;

   // written sizes keep only the coordinate bits
   localparam logic [DIM_BITS-1:0] DimMask =
      (COORD_BITS >= DIM_BITS) ? {DIM_BITS{1'b1}} : DIM_BITS'((1 << COORD_BITS) - 1);
   localparam int OpW  = $bits(op_type);
   localparam int RspW = 2 + 2 * COORD_BITS + GLYPH_BITS + 1;

   // configuration registers
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [1:0]          scale_ff, scale_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      scale_in  = scale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wdata & DimMask;
            CSR_SCREEN_HEIGHT: height_in = csr_wdata & DimMask;
            CSR_PIXEL_SCALE:   scale_in  = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SCREEN_WIDTH_RST;
         height_ff <= SCREEN_HEIGHT_RST;
         scale_ff  <= PIXEL_SCALE_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         scale_ff  <= scale_in;
      end
   end

   // front: classify and look up the glyph
   logic   op_push, op_full, op_empty, op_pop;
   op_type op_front;
   logic [OpW-1:0] op_head;

   tcle_front u_front (
      .req_push         (req_push),
      .req_command      (req_command),
      .req_text_byte    (req_text_byte),
      .req_last_of_text (req_last_of_text),
      .op_full          (op_full),
      .op_push          (op_push),
      .op               (op_front)
   );

   // full reflects the op queue; ignored bytes still count as a transfer
   assign req_full = op_full;

   tcle_fifo #(
      .WIDTH (OpW),
      .DEPTH (OP_QUEUE_DEPTH)
   ) u_op_queue (
      .clock (clock),
      .reset (reset),
      .push  (op_push),
      .wdata (op_front),
      .full  (op_full),
      .pop   (op_pop),
      .rdata (op_head),
      .empty (op_empty)
   );

   // back: cursor and result sequencing
   logic                  res_push, res_full, res_last;
   logic [1:0]            res_action;
   logic [COORD_BITS-1:0] res_cell_x, res_cell_y;
   logic [GLYPH_BITS-1:0] res_glyph_bits;
   logic [RspW-1:0]       rsp_word;

   tcle_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .screen_width   (width_ff),
      .screen_height  (height_ff),
      .pixel_scale    (scale_ff),
      .op_valid       (!op_empty),
      .op             (op_type'(op_head)),
      .op_pop         (op_pop),
      .res_full       (res_full),
      .res_push       (res_push),
      .res_action     (res_action),
      .res_cell_x     (res_cell_x),
      .res_cell_y     (res_cell_y),
      .res_glyph_bits (res_glyph_bits),
      .res_last       (res_last)
   );

   // result queue decouples the sequencer from the receiver
   tcle_fifo #(
      .WIDTH (RspW),
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata ({res_action, res_cell_x, res_cell_y, res_glyph_bits, res_last}),
      .full  (res_full),
      .pop   (rsp_pop),
      .rdata (rsp_word),
      .empty (rsp_empty)
   );

   assign rsp_last       = rsp_word[0];
   assign rsp_glyph_bits = rsp_word[GLYPH_BITS:1];
   assign rsp_cell_y     = rsp_word[GLYPH_BITS + COORD_BITS:GLYPH_BITS + 1];
   assign rsp_cell_x     = rsp_word[GLYPH_BITS + 2 * COORD_BITS:GLYPH_BITS + COORD_BITS + 1];
   assign rsp_action     = rsp_word[RspW-1:RspW-2];

endmodule

### rtl/tcle_checker.sv
// ----------------------------------------------------------------------------
// tcle_checker: port level checks of the text cell layout engine
// watches the result queue side for well formed results
// ----------------------------------------------------------------------------
module tcle_checker #(
   parameter int COORD_BITS = tcle_pkg::COORD_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_empty,
   input logic [1:0]                      rsp_action,
   input logic [COORD_BITS-1:0]           rsp_cell_x,
   input logic [COORD_BITS-1:0]           rsp_cell_y,
   input logic [tcle_pkg::GLYPH_BITS-1:0] rsp_glyph_bits,
   input logic                            rsp_last
);
   import tcle_pkg::*;

   // nothing waits right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result queue not empty after reset");

   // only the three defined actions leave the block
   a_action_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_action == ACT_CLEAR || rsp_action == ACT_DRAW ||
                      rsp_action == ACT_REFRESH))
      else $error("undefined action code");

   // clear and refresh carry no cell
   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_action != ACT_DRAW) |->
         (rsp_cell_x == '0 && rsp_cell_y == '0 && rsp_glyph_bits == '0))
      else $error("clear or refresh with nonzero payload");

   // a refresh always closes the results of its input
   a_refresh_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_action == ACT_REFRESH) |-> rsp_last)
      else $error("refresh not marked last");

endmodule

bind text_cell_layout_engine tcle_checker #(
   .COORD_BITS (COORD_BITS)
) u_tcle_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_action     (rsp_action),
   .rsp_cell_x     (rsp_cell_x),
   .rsp_cell_y     (rsp_cell_y),
   .rsp_glyph_bits (rsp_glyph_bits),
   .rsp_last       (rsp_last)
);

### test/tcle_layout_tracker_pkg.sv
// ----------------------------------------------------------------------------
// tcle_layout_tracker_pkg: expected command stream of the text cell layout engine
// tracks cursor, screen size and scale, predicts clear, draw and refresh
// commands per input transfer and checks them in order against the block
// ----------------------------------------------------------------------------
package tcle_layout_tracker_pkg;
   import tcle_pkg::*;

   typedef struct packed {
      logic [1:0]            action;
      logic [DIM_BITS-1:0]   cell_x;
      logic [DIM_BITS-1:0]   cell_y;
      logic [GLYPH_BITS-1:0] glyph;
      logic                  last;
   } cell_cmd_type;

   class layout_tracker;
      int unsigned  width;
      int unsigned  height;
      int unsigned  scale;
      int unsigned  pen_col;
      int unsigned  pen_row;
      cell_cmd_type pending_cmds[$];
      cell_cmd_type batch[$];
      int           mismatches;
      int           checked;

      function void restore_defaults();
         width  = 32'(SCREEN_WIDTH_RST);
         height = 32'(SCREEN_HEIGHT_RST);
         scale  = 32'(PIXEL_SCALE_RST);
         home();
      endfunction

      function void write_reg(logic [1:0] index, logic [DIM_BITS-1:0] data);
         case (index)
            CSR_SCREEN_WIDTH:  width  = 32'(data);
            CSR_SCREEN_HEIGHT: height = 32'(data);
            CSR_PIXEL_SCALE:   scale  = 32'(data[1:0]);
            default: ;
         endcase
      endfunction

      function int unsigned unit();
         return (scale == 0) ? 1 : scale;
      endfunction

      function void home();
         pen_col = 2 * unit();
         pen_row = 2 * unit();
      endfunction

      // columns listed left to right, one byte each, top row in bit 0
      function logic [GLYPH_BITS-1:0] font_lookup(logic [7:0] chr);
         logic [7:0]            up;
         logic [39:0]           cols;
         logic [GLYPH_BITS-1:0] packed_cols;
         up = (chr >= "a" && chr <= "z") ? chr - 8'd32 : chr;
         case (up)
            " ":  cols = 40'h00_00_00_00_00;
            "0":  cols = 40'h3E_51_49_45_3E;
            "1":  cols = 40'h00_42_7F_40_00;
            "2":  cols = 40'h42_61_51_49_46;
            "3":  cols = 40'h21_41_45_4B_31;
            "4":  cols = 40'h18_14_12_7F_10;
            "5":  cols = 40'h27_45_45_45_39;
            "6":  cols = 40'h3C_4A_49_49_30;
            "7":  cols = 40'h01_71_09_05_03;
            "8":  cols = 40'h36_49_49_49_36;
            "9":  cols = 40'h06_49_49_29_1E;
            "A":  cols = 40'h7E_11_11_11_7E;
            "B":  cols = 40'h7F_49_49_49_36;
            "C":  cols = 40'h3E_41_41_41_22;
            "D":  cols = 40'h7F_41_41_22_1C;
            "E":  cols = 40'h7F_49_49_49_41;
            "F":  cols = 40'h7F_09_09_09_01;
            "G":  cols = 40'h3E_41_49_49_7A;
            "H":  cols = 40'h7F_08_08_08_7F;
            "I":  cols = 40'h00_41_7F_41_00;
            "J":  cols = 40'h20_40_41_3F_01;
            "K":  cols = 40'h7F_08_14_22_41;
            "L":  cols = 40'h7F_40_40_40_40;
            "M":  cols = 40'h7F_02_0C_02_7F;
            "N":  cols = 40'h7F_04_08_10_7F;
            "O":  cols = 40'h3E_41_41_41_3E;
            "P":  cols = 40'h7F_09_09_09_06;
            "Q":  cols = 40'h3E_41_51_21_5E;
            "R":  cols = 40'h7F_09_19_29_46;
            "S":  cols = 40'h46_49_49_49_31;
            "T":  cols = 40'h01_01_7F_01_01;
            "U":  cols = 40'h3F_40_40_40_3F;
            "V":  cols = 40'h1F_20_40_20_1F;
            "W":  cols = 40'h3F_40_38_40_3F;
            "X":  cols = 40'h63_14_08_14_63;
            "Y":  cols = 40'h07_08_70_08_07;
            "Z":  cols = 40'h61_51_49_45_43;
            "!":  cols = 40'h00_00_5F_00_00;
            "\"": cols = 40'h00_07_00_07_00;
            "'":  cols = 40'h00_05_03_00_00;
            ",":  cols = 40'h00_50_30_00_00;
            "-":  cols = 40'h08_08_08_08_08;
            ".":  cols = 40'h00_60_60_00_00;
            ":":  cols = 40'h00_36_36_00_00;
            ";":  cols = 40'h00_56_36_00_00;
            "/":  cols = 40'h20_10_08_04_02;
            "(":  cols = 40'h00_1C_22_41_00;
            ")":  cols = 40'h00_41_22_1C_00;
            default: cols = 40'h02_01_51_09_06;
         endcase
         for (int c = 0; c < 5; c++) begin
            packed_cols[7*c +: 7] = cols[8*(4-c) +: 7];
         end
         return packed_cols;
      endfunction

      function void add_cmd(logic [1:0] action, int unsigned x, int unsigned y,
                            logic [GLYPH_BITS-1:0] glyph);
         cell_cmd_type c;
         c.action = action;
         c.cell_x = DIM_BITS'(x);
         c.cell_y = DIM_BITS'(y);
         c.glyph  = glyph;
         c.last   = 1'b0;
         batch.push_back(c);
      endfunction

      function void line_feed();
         int unsigned s;
         s = unit();
         pen_col = 2 * s;
         pen_row = (pen_row + 9 * s) & 32'hFFF;
         // next line would run off the bottom: wipe and start over
         if (pen_row + 7 * s > height) begin
            add_cmd(ACT_CLEAR, 0, 0, '0);
            home();
         end
      endfunction

      function void put_cell(logic [7:0] chr);
         int unsigned step;
         step = 6 * unit();
         if (pen_col + step > width) begin
            line_feed();
         end
         add_cmd(ACT_DRAW, pen_col, pen_row, font_lookup(chr));
         pen_col = (pen_col + step) & 32'hFFF;
      endfunction

      // one accepted input transfer
      function void note_byte(logic command, logic [7:0] chr, logic fin);
         cell_cmd_type c;
         batch.delete();
         if (command) begin
            add_cmd(ACT_CLEAR, 0, 0, '0);
            home();
         end else if (chr == CHR_LF) begin
            line_feed();
         end else if (chr == CHR_CR) begin
            // dropped
         end else if (chr >= CHR_SPACE && chr < CHR_DEL) begin
            put_cell(chr);
         end else if ((chr & UTF8_TOP) != UTF8_CONT) begin
            put_cell(CHR_QMARK);
         end
         if (fin) begin
            add_cmd(ACT_REFRESH, 0, 0, '0);
         end
         foreach (batch[i]) begin
            c = batch[i];
            c.last = (i == batch.size() - 1);
            pending_cmds.push_back(c);
         end
      endfunction

      function int pending();
         return pending_cmds.size();
      endfunction

      function void check_cell(cell_cmd_type got);
         cell_cmd_type want;
         checked++;
         if (pending_cmds.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual action %0d x %0d y %0d",
                     $time, got.action, got.cell_x, got.cell_y);
            return;
         end
         want = pending_cmds.pop_front();
         if (got.action !== want.action) begin
            mismatches++;
            $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
         end
         if (got.cell_x !== want.cell_x) begin
            mismatches++;
            $display("%0t: cell_x expected %0d actual %0d", $time, want.cell_x, got.cell_x);
         end
         if (got.cell_y !== want.cell_y) begin
            mismatches++;
            $display("%0t: cell_y expected %0d actual %0d", $time, want.cell_y, got.cell_y);
         end
         if (got.glyph !== want.glyph) begin
            mismatches++;
            $display("%0t: glyph_bits expected %h actual %h", $time, want.glyph, got.glyph);
         end
         if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
         end
      endfunction
   endclass

endpackage

### test/tb_text_cell_layout_engine.sv
// ----------------------------------------------------------------------------
// tb_text_cell_layout_engine: self-checking bench for the text cell layout engine
// directed bytes, then random text over several screen setups, with random
// gaps on both queues and one long receiver hold that backs up the input
// ----------------------------------------------------------------------------
module tb_text_cell_layout_engine;
   import tcle_pkg::*;
   import tcle_layout_tracker_pkg::*;

   localparam int NUM_SETUPS   = 7;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push         = 1'b0;
   logic                  req_full;
   logic                  req_command      = 1'b0;
   logic [7:0]            req_text_byte    = 8'h00;
   logic                  req_last_of_text = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop          = 1'b0;
   logic [1:0]            rsp_action;
   logic [DIM_BITS-1:0]   rsp_cell_x;
   logic [DIM_BITS-1:0]   rsp_cell_y;
   logic [GLYPH_BITS-1:0] rsp_glyph_bits;
   logic                  rsp_last;
   logic                  csr_wr_en        = 1'b0;
   logic [1:0]            csr_index        = CSR_SCREEN_WIDTH;
   logic [DIM_BITS-1:0]   csr_wdata        = '0;

   layout_tracker tracker;

   // idling knobs, shared between the stimulus and the result sink
   bit sender_idles = 1'b1;
   bit sink_idles   = 1'b1;
   bit hold_request = 1'b0;

   int input_count = 0;
   int cycles      = 0;

   // characters that have their own glyph in the font
   string font_chars =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789 !\"',-.:;?/()";

   // screen setups, width / height / scale; setup 5 is drawn at run time
   int unsigned setup_width[NUM_SETUPS]  = '{2047, 1, 40, 0, 100, 0, 320};
   int unsigned setup_height[NUM_SETUPS] = '{2047, 1, 30, 7, 60, 0, 240};
   int unsigned setup_scale[NUM_SETUPS]  = '{3, 3, 2, 0, 1, 0, 1};
   int          setup_items[NUM_SETUPS]  = '{25, 15, 35, 15, 30, 30, 40};

   always #10 clock = ~clock;

   text_cell_layout_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (req_command),
      .req_text_byte    (req_text_byte),
      .req_last_of_text (req_last_of_text),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_action       (rsp_action),
      .rsp_cell_x       (rsp_cell_x),
      .rsp_cell_y       (rsp_cell_y),
      .rsp_glyph_bits   (rsp_glyph_bits),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result sink: check each transfer, then pick pop for the next edge
   initial begin : result_sink
      int           stall_left;
      cell_cmd_type got;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.action = rsp_action;
            got.cell_x = rsp_cell_x;
            got.cell_y = rsp_cell_y;
            got.glyph  = rsp_glyph_bits;
            got.last   = rsp_last;
            tracker.check_cell(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (hold_request) begin
            // long hold, counted here so the sender keeps pushing meanwhile
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            rsp_pop <= 1'b0;
         end else if (sink_idles && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // offer one input and wait for its transfer; push stays high afterward
   // so the next call can keep the stream back to back
   task automatic send_byte(input logic command, input logic [7:0] chr, input logic fin);
      int gap;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push         <= 1'b1;
      req_command      <= command;
      req_text_byte    <= chr;
      req_last_of_text <= fin;
      do @(posedge clock); while (req_full);
      tracker.note_byte(command, chr, fin);
      input_count++;
   endtask

   // mostly real text with the odd control, lead or continuation byte
   task automatic send_random_byte();
      int         pick;
      logic       command;
      logic [7:0] chr;
      pick    = $urandom_range(0, 99);
      command = 1'b0;
      if (pick < 5) begin
         command = 1'b1;
         chr = 8'($urandom_range(0, 255));
      end else if (pick < 15) begin
         chr = CHR_LF;
      end else if (pick < 20) begin
         chr = CHR_CR;
      end else if (pick < 70) begin
         chr = font_chars[$urandom_range(0, font_chars.len() - 1)];
      end else if (pick < 85) begin
         chr = 8'($urandom_range(32, 126));
      end else if (pick < 95) begin
         chr = 8'($urandom_range(128, 255));
      end else begin
         chr = 8'($urandom_range(0, 31));
      end
      send_byte(command, chr, $urandom_range(0, 6) == 0);
   endtask

   // stop offering and let every expected result come out, plus a margin
   // for bytes that cause nothing but may still be in flight
   task automatic drain();
      req_push <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // all three registers, one per edge, while the block is idle
   task automatic set_screen(input int unsigned w, input int unsigned h,
                             input int unsigned s);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_wdata <= DIM_BITS'(w);
      @(posedge clock);
      tracker.write_reg(CSR_SCREEN_WIDTH, DIM_BITS'(w));
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_wdata <= DIM_BITS'(h);
      @(posedge clock);
      tracker.write_reg(CSR_SCREEN_HEIGHT, DIM_BITS'(h));
      csr_index <= CSR_PIXEL_SCALE;
      csr_wdata <= DIM_BITS'(s);
      @(posedge clock);
      tracker.write_reg(CSR_PIXEL_SCALE, DIM_BITS'(s));
      csr_wr_en <= 1'b0;
   endtask

   initial begin : stimulus
      tracker = new();
      tracker.restore_defaults();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset sizes
      send_byte(1'b1, 8'h00, 1'b0);       // clear without refresh
      send_byte(1'b0, "A", 1'b0);
      send_byte(1'b0, "z", 1'b0);         // folded to upper case
      send_byte(1'b0, "0", 1'b0);
      send_byte(1'b0, "9", 1'b0);
      send_byte(1'b0, CHR_SPACE, 1'b0);   // blank cell
      send_byte(1'b0, "~", 1'b0);         // printable without a glyph
      send_byte(1'b0, "!", 1'b0);
      send_byte(1'b0, ")", 1'b0);
      send_byte(1'b0, CHR_CR, 1'b0);      // nothing at all
      send_byte(1'b0, CHR_CR, 1'b1);      // refresh only
      send_byte(1'b0, UTF8_CONT, 1'b0);   // continuation, dropped
      send_byte(1'b0, 8'hBF, 1'b0);
      send_byte(1'b0, UTF8_TOP, 1'b0);    // lead byte draws a question mark
      send_byte(1'b0, 8'hFF, 1'b0);
      send_byte(1'b0, 8'h00, 1'b0);       // control byte
      send_byte(1'b0, CHR_DEL, 1'b0);
      send_byte(1'b0, CHR_LF, 1'b0);
      send_byte(1'b1, 8'hFF, 1'b1);       // clear with refresh
      send_byte(1'b0, 8'h01, 1'b1);
      drain();

      for (int p = 0; p < NUM_SETUPS; p++) begin
         if (p == 5) begin
            setup_width[p]  = $urandom_range(30, 400);
            setup_height[p] = $urandom_range(20, 300);
            setup_scale[p]  = $urandom_range(1, 3);
         end
         set_screen(setup_width[p], setup_height[p], setup_scale[p]);
         // last setup runs flat out on both sides
         sender_idles = (p != NUM_SETUPS - 1);
         sink_idles   = (p != NUM_SETUPS - 1);
         // small screen: receiver holds while the sender keeps pushing
         if (p == 2) begin
            sender_idles = 1'b0;
            hold_request = 1'b1;
         end
         repeat (setup_items[p]) send_random_byte();
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d input transfers and %0d result transfers over %0d screen setups",
               input_count, tracker.checked, NUM_SETUPS + 1);
      $display("setups ranged from a zero and one pixel screen to 2047x2047 at scale 0 to 3");
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
rtl/tcle_pkg.sv
rtl/tcle_fifo.sv
rtl/tcle_front.sv
rtl/tcle_back.sv
rtl/text_cell_layout_engine.sv
rtl/tcle_checker.sv
test/tcle_layout_tracker_pkg.sv
test/tb_text_cell_layout_engine.sv
